>>> rtl/core/sha_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; imported by sha_ctrl, sha_dp and the top level.
package sha_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int FILL_W  = 6;
  localparam int ROUND_W = 6;
  localparam int CNT_W   = 61;
  localparam int IDX_W   = 3;
  localparam int NWORDS  = 8;
  localparam int SCHED_W = 512;

  localparam logic [BYTE_W-1:0]  PAD_MARK        = 8'h80;
  localparam logic [FILL_W-1:0]  FILL_LAST       = 6'd63;
  localparam logic [FILL_W-1:0]  FILL_BEFORE_LEN = 6'd55;
  localparam logic [ROUND_W-1:0] ROUND_LAST      = 6'd63;
  localparam logic [IDX_W-1:0]   IDX_LAST        = 3'd7;

  localparam logic [WORD_W-1:0] IV_TAB [NWORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Controller to datapath commands
  typedef struct packed {
    logic put;        // shift one byte into the block buffer
    logic put_pad;    // byte comes from the padding generator
    logic count;      // bump the message length
    logic pad_begin;  // rewind the padding generator
    logic comp_start; // load working variables from the chain value
    logic round;      // run one compression round
    logic comp_fin;   // fold working variables into the chain value
    logic out_load;   // copy the digest into the output buffer
    logic out_shift;  // advance the output buffer by one word
    logic restart;    // return to the initial hash value
  } sha_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill_full;  // next byte completes the block
    logic round_last; // current round is the 64th
    logic pad_last;   // current pad byte is the last length byte
  } sha_stat_t;

endpackage

>>> rtl/core/sha_ctrl.sv
// Controller state machine for the SHA-256 stream hasher.
// Depends on sha_pkg; drives sha_dp through sha_cmd_t and reads sha_stat_t.
module sha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_tuser,
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [2:0]         m_tuser,
  output logic               m_tlast,
  output sha_pkg::sha_cmd_t  cmd,
  input  sha_pkg::sha_stat_t stat
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FIN,
    S_PAD,
    S_DONE
  } state_t;

  state_t           state;
  logic             pad_mode;
  logic             pad_end;
  logic             out_busy;
  logic [IDX_W-1:0] out_idx;
  logic             in_acc;
  logic             m_acc;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign m_acc    = out_busy && m_tready;
  assign m_tvalid = out_busy;
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == IDX_LAST);

  always_comb begin
    cmd = '0;
    cmd.out_shift = m_acc;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          cmd.put       = s_tuser;
          cmd.count     = s_tuser;
          cmd.pad_begin = s_tlast;
        end
      end
      S_LOAD:  cmd.comp_start = 1'b1;
      S_ROUND: cmd.round      = 1'b1;
      S_FIN:   cmd.comp_fin   = 1'b1;
      S_PAD: begin
        cmd.put     = 1'b1;
        cmd.put_pad = 1'b1;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.restart  = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pad_mode <= 1'b0;
      pad_end  <= 1'b0;
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else begin
      if (m_acc) begin
        out_idx <= out_idx + 1'b1;
        if (out_idx == IDX_LAST) out_busy <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            pad_end <= 1'b0;
            if (s_tuser && stat.fill_full) begin
              state    <= S_LOAD;
              pad_mode <= s_tlast;
            end else if (s_tlast) begin
              state    <= S_PAD;
              pad_mode <= 1'b1;
            end
          end
        end
        S_LOAD: state <= S_ROUND;
        S_ROUND: begin
          if (stat.round_last) state <= S_FIN;
        end
        S_FIN: begin
          if (pad_end)       state <= S_DONE;
          else if (pad_mode) state <= S_PAD;
          else               state <= S_IDLE;
        end
        S_PAD: begin
          if (stat.pad_last)  pad_end <= 1'b1;
          if (stat.fill_full) state   <= S_LOAD;
        end
        S_DONE: begin
          // hold until the previous digest has drained
          if (!out_busy) begin
            state    <= S_IDLE;
            pad_mode <= 1'b0;
            pad_end  <= 1'b0;
            out_busy <= 1'b1;
            out_idx  <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/sha_dp.sv
// Datapath for the SHA-256 stream hasher: block buffer / schedule window,
// round logic, chain value, padding generator and digest output buffer.
// Depends on sha_pkg; controlled by sha_ctrl.
module sha_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  sha_pkg::sha_cmd_t         cmd,
  output sha_pkg::sha_stat_t        stat,
  input  logic [sha_pkg::BYTE_W-1:0] msg_byte,
  output logic [sha_pkg::WORD_W-1:0] digest_word
);
  import sha_pkg::*;

  function automatic logic [WORD_W-1:0] big_s0(input logic [WORD_W-1:0] x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] big_s1(input logic [WORD_W-1:0] x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] sml_s0(input logic [WORD_W-1:0] x);
    sml_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] sml_s1(input logic [WORD_W-1:0] x);
    sml_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  logic [SCHED_W-1:0] sched;
  logic [WORD_W-1:0]  chain [NWORDS];
  logic [WORD_W-1:0]  v     [NWORDS];
  logic [WORD_W-1:0]  obuf  [NWORDS];
  logic [FILL_W-1:0]  fill;
  logic [CNT_W-1:0]   byte_count;
  logic [ROUND_W-1:0] rnd;
  logic               sent_mark;
  logic               len_active;
  logic [IDX_W-1:0]   len_idx;

  logic [63:0]        bit_len;
  logic [BYTE_W-1:0]  pad_byte;
  logic [BYTE_W-1:0]  in_byte;
  logic [WORD_W-1:0]  w_t, w_new, t1, t2, ch, mj;

  assign bit_len = {byte_count, 3'b000};

  always_comb begin
    if (!sent_mark)       pad_byte = PAD_MARK;
    else if (!len_active) pad_byte = '0;
    else                  pad_byte = bit_len[{IDX_LAST - len_idx, 3'b000} +: BYTE_W];
  end

  assign in_byte = cmd.put_pad ? pad_byte : msg_byte;

  // window holds W[t..t+15], W[t] in the top word
  assign w_t   = sched[511:480];
  assign w_new = w_t + sml_s0(sched[479:448]) + sched[223:192] + sml_s1(sched[63:32]);
  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign mj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + big_s1(v[4]) + ch + K_TAB[rnd] + w_t;
  assign t2    = big_s0(v[0]) + mj;

  assign stat.fill_full  = (fill == FILL_LAST);
  assign stat.round_last = (rnd == ROUND_LAST);
  assign stat.pad_last   = len_active && (len_idx == IDX_LAST);
  assign digest_word     = obuf[0];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      byte_count <= '0;
      rnd        <= '0;
      sent_mark  <= 1'b0;
      len_active <= 1'b0;
      len_idx    <= '0;
      for (int i = 0; i < NWORDS; i++) chain[i] <= IV_TAB[i];
    end else begin
      if (cmd.put)   fill <= fill + 1'b1;
      if (cmd.count) byte_count <= byte_count + 1'b1;
      if (cmd.pad_begin) begin
        sent_mark  <= 1'b0;
        len_active <= 1'b0;
        len_idx    <= '0;
      end else if (cmd.put && cmd.put_pad) begin
        sent_mark <= 1'b1;
        if (len_active)                  len_idx    <= len_idx + 1'b1;
        else if (fill == FILL_BEFORE_LEN) len_active <= 1'b1;
      end
      if (cmd.comp_start) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 1'b1;
      if (cmd.restart) begin
        fill       <= '0;
        byte_count <= '0;
        for (int i = 0; i < NWORDS; i++) chain[i] <= IV_TAB[i];
      end else if (cmd.comp_fin) begin
        for (int i = 0; i < NWORDS; i++) chain[i] <= chain[i] + v[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.put) sched <= {sched[SCHED_W-BYTE_W-1:0], in_byte};
    else if (cmd.round) sched <= {sched[SCHED_W-WORD_W-1:0], w_new};

    if (cmd.comp_start) begin
      for (int i = 0; i < NWORDS; i++) v[i] <= chain[i];
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end

    if (cmd.out_load) begin
      for (int i = 0; i < NWORDS; i++) obuf[i] <= chain[i];
    end else if (cmd.out_shift) begin
      for (int i = 0; i < NWORDS - 1; i++) obuf[i] <= obuf[i+1];
    end
  end

endmodule

>>> rtl/core/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Depends on sha_pkg, sha_ctrl and sha_dp.
//
//  channel  dir  tdata             tuser          tlast
//  s_*      in   message_byte[7:0] byte_valid     end_of_message
//  m_*      out  digest_word[31:0] word_index[2:0] final_word
//
// Bytes are taken while idle; each full 64-byte block then stalls input for
// its compression (load, 64 rounds on the single round unit, chain fold).
// End of message adds padding bytes (marker, zeros, 64-bit length) and one or
// two more compressions, then eight output transactions from the digest buffer.
// The next message is taken while the digest drains; its end waits for the
// buffer to empty. Reset is synchronous and restores the initial hash value.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] message_byte
  input  logic        s_tuser,  // [0] byte_valid
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] digest_word
  output logic [2:0]  m_tuser,  // [2:0] word_index
  output logic        m_tlast
);
  import sha_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;

  sha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .msg_byte    (s_tdata),
    .digest_word (m_tdata)
  );

`ifndef SYNTHESIS
  // the last length byte must land at the final buffer position
  a_len_align: assert property (@(posedge clk) disable iff (rst)
    (cmd.put && stat.pad_last) |-> stat.fill_full)
    else $error("length field misaligned in padding block");

  a_no_accept_in_round: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> !s_tready)
    else $error("input accepted during compression");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("digest output continued past final word");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (m_tuser == 3'($past(m_tuser) + 3'd1))))
    else $error("digest word index did not advance");
`endif

endmodule

>>> verif/tb_sha256_stream_hasher_top.sv
// Self-checking testbench for sha256_stream_hasher_top: streams message bytes in,
// predicts every digest word with a local SHA-256 model and checks the output stream.
// Depends on the RTL top level only.
module tb_sha256_stream_hasher_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int TAIL_ITEMS   = 40;
  localparam int RAND_ITEMS   = 200;
  localparam int MAX_REPORTS  = 10;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_FIELD_AT = 6'd56;
  localparam logic [2:0] LAST_WORD    = 3'd7;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        is_last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // [7:0] message_byte
  logic        s_tuser = 1'b0;   // [0] byte_valid
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [31:0] digest_word
  logic [2:0]  m_tuser;          // [2:0] word_index
  logic        m_tlast;

  sha256_stream_hasher_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  msg_item_t    byte_feed[$];
  digest_word_t pending_digest[$];
  digest_word_t want;

  // hash state of the local model
  logic [31:0] chain_h [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  block_fill;
  logic [60:0] msg_len;

  int stim_items     = 0;
  int bytes_sent     = 0;
  int words_checked  = 0;
  int messages_seen  = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int src_gap        = 0;
  int snk_gap        = 0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, g0, g1, w15, w2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++)
      v[i] = chain_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        w15 = w[(t - 15) & 15];
        w2  = w[(t - 2) & 15];
        g0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        g1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        wt = w[t & 15] + g0 + w[(t - 7) & 15] + g1;
        w[t & 15] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0)
      compress_block();
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++)
      chain_h[i] = INIT_H[i];
    block_fill = '0;
    msg_len = '0;
  endfunction

  // Fold one accepted transaction into the model; a message end queues eight words.
  function automatic void hash_item(input msg_item_t it);
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (it.present) begin
      msg_len = msg_len + 61'd1;
      absorb_byte(it.data);
    end
    if (it.last) begin
      bit_len = {msg_len, 3'b000};
      absorb_byte(PAD_BYTE);
      while (block_fill != LEN_FIELD_AT)
        absorb_byte(8'h00);
      for (int i = 0; i < 8; i++)
        absorb_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.word    = chain_h[i];
        dw.idx     = 3'(i);
        dw.is_last = (3'(i) == LAST_WORD);
        pending_digest = {pending_digest, dw};
      end
      restart_hash();
    end
  endfunction

  task automatic push_item(input logic [7:0] data, input logic present, input logic last);
    msg_item_t it;
    it.data = data;
    it.present = present;
    it.last = last;
    byte_feed = {byte_feed, it};
    if (present || last)
      stim_items++;
  endtask

  // Random bytes with idle transactions mixed in; end either on the last byte
  // or on a separate terminator with no byte.
  task automatic queue_message(input int len, input bit end_on_byte, input int idle_pct);
    for (int i = 0; i < len; i++) begin
      while ($urandom_range(0, 99) < idle_pct)
        push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, (end_on_byte && i == len - 1));
    end
    if (len == 0 || !end_on_byte)
      push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycle_count, pending_digest.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Driver: hold each transaction until accepted, then pull the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        hash_item(msg_item_t'({s_tdata, s_tuser, s_tlast}));
        if (s_tuser)
          bytes_sent++;
      end
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (byte_feed.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(0, 4);
        s_tvalid <= 1'b0;
      end else if (byte_feed.size() != 0) begin
        s_tdata <= byte_feed[0].data;
        s_tuser <= byte_feed[0].present;
        s_tlast <= byte_feed[0].last;
        s_tvalid <= 1'b1;
        void'(byte_feed.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each output transaction with the oldest predicted word.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_digest.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected digest word %h index %0d last %b",
                     m_tdata, m_tuser, m_tlast);
        end else begin
          want = pending_digest.pop_front();
          words_checked++;
          if (want.is_last)
            messages_seen++;
          if (m_tdata !== want.word || m_tuser !== want.idx || m_tlast !== want.is_last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                       want.word, want.idx, want.is_last, m_tdata, m_tuser, m_tlast);
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap <= snk_gap - 1;
        m_tready <= 1'b0;
      end else if (byte_feed.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
        snk_gap <= $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int len;
    int pick;
    int boundary_len [4];
    boundary_len = '{55, 56, 63, 64};
    restart_hash();

    // empty message, then an idle transaction with all data bits set
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b0);
    // single bytes at both extremes, ended on the byte and by a terminator
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    // "abc", with an idle transaction inside the message
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    // back-to-back empty messages
    push_item(8'h5a, 1'b0, 1'b1);
    push_item(8'ha5, 1'b0, 1'b1);

    // padding spills into an extra block, then an exact full block
    queue_message(56, 1'b1, 5);
    queue_message(64, 1'b0, 5);
    while (stim_items < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        len = $urandom_range(0, 10);
      else if (pick < 8)
        len = $urandom_range(11, 40);
      else
        len = boundary_len[$urandom_range(0, 3)];
      queue_message(len, 1'($urandom_range(0, 1)), 10);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (byte_feed.size() != 0 || s_tvalid)
      @(posedge clk);
    while (pending_digest.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("hashed %0d messages from %0d bytes; %0d digest words checked, %0d mismatches",
             messages_seen, bytes_sent, words_checked, mismatches);
    if (mismatches == 0 && pending_digest.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
